// ===== sv/nmea_rmc_speed_extractor_macros.svh =====
// assertion macros shared by the nmea rmc speed extractor top level and parser modules
`ifndef NMEA_RMC_SPEED_EXTRACTOR_MACROS_SVH
`define NMEA_RMC_SPEED_EXTRACTOR_MACROS_SVH

// clocked check, disabled while reset is asserted
`define NMEA_RMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked check that also holds during reset
`define NMEA_RMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== sv/nmea_rmc_pkg.sv =====
// types and constants for the nmea rmc speed extractor
`timescale 1ns / 1ps
`default_nettype none

package nmea_rmc_pkg;

  localparam int BYTE_W  = 8;
  localparam int SPEED_W = 17;
  localparam int FIDX_W  = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // characters of interest
  localparam logic [BYTE_W-1:0] CHAR_P      = 8'h50;
  localparam logic [BYTE_W-1:0] CHAR_R      = 8'h52;
  localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_POINT  = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

  // value clamp in hundredths of a knot
  localparam logic [SPEED_W-1:0] SPEED_MAX = 17'd99999;

  // register map, index taken from paddr[2]
  localparam logic REG_FIELD_INDEX = 1'b0;
  localparam logic [FIDX_W-1:0] FIELD_INDEX_RESET = 4'd7;

  // result word from the parser to the output register
  typedef struct packed {
    logic               emit;
    logic [SPEED_W-1:0] speed;
    logic               sat;
  } rmc_result_t;

endpackage

`default_nettype wire

// ===== sv/nmea_rmc_speed_extractor.sv =====
// top level: input register, parser, result register and config port
//
// nmea rmc speed extractor
// rx channel: one received character per word on rx_byte_i, accepted at a
//   clock edge with rx_valid_i high and rx_stall_o low.
// result channel: speed_hundredths_o and saturated_o, taken at an edge with
//   out_valid_o high and out_stall_i low. one word per rmc sentence, issued
//   on the comma that closes the selected field.
// config: apb-style port, one register at byte address 0 (field_index,
//   low 4 bits, reset 7 for speed over ground). pready is tied high.
// path: a closing comma is first captured in the input register, and its
//   result is written to the result register when the parser takes it.
// throughput: one character per cycle while no result is stalled; the parser
//   state loop is closed through compare and multiply-by-ten logic.
// stall: a stalled result holds; the input register keeps feeding bytes
//   that give no result and holds only the next closing comma.
// reset: parser idle waiting for a "PR" tag, both registers empty.
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_rmc_speed_extractor_macros.svh"

module nmea_rmc_speed_extractor (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              rx_valid_i,
  output logic                                   rx_stall_o,
  input  wire logic [nmea_rmc_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [nmea_rmc_pkg::SPEED_W-1:0] speed_hundredths_o,
  output logic                                   saturated_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [nmea_rmc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [nmea_rmc_pkg::PDATA_W-1:0] pwdata,
  output logic      [nmea_rmc_pkg::PDATA_W-1:0] prdata,
  output logic                                   pready
);
  import nmea_rmc_pkg::*;

  logic               in_vld_q, in_vld_d;
  logic [BYTE_W-1:0]  in_byte_q;
  logic               out_vld_q, out_vld_d;
  logic [SPEED_W-1:0] out_speed_q;
  logic               out_sat_q;
  logic               in_take;
  logic               advance;
  logic               out_free;
  logic [FIDX_W-1:0]  field_index;
  rmc_result_t        res;

  // configuration register
  nmea_rmc_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_o      (prdata),
    .pready_o      (pready),
    .field_index_o (field_index)
  );

  // parser works on the registered byte
  nmea_rmc_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_i        (in_byte_q),
    .take_i        (advance),
    .field_index_i (field_index),
    .res_o         (res)
  );

  // handshake control
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!res.emit || out_free);
  assign rx_stall_o = in_vld_q && !advance;
  assign in_take    = rx_valid_i && !rx_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && res.emit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && res.emit) begin
      out_speed_q <= res.speed;
      out_sat_q   <= res.sat;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign speed_hundredths_o = out_speed_q;
  assign saturated_o        = out_sat_q;

  // input side only holds off when a byte is waiting
  `NMEA_RMC_ASSERT_ALWAYS(a_stall_needs_word, rx_stall_o |-> in_vld_q, "stall with empty stage")
  // a stalled result is never dropped
  `NMEA_RMC_ASSERT(a_out_hold, (out_vld_q && out_stall_i) |=> out_vld_q, "result dropped")
  // a result never overwrites one still waiting
  `NMEA_RMC_ASSERT(a_no_overwrite, (advance && res.emit) |-> out_free, "result overwritten")

endmodule

`default_nettype wire

// ===== sv/nmea_rmc_cfg.sv =====
// apb-style register holding the field index
`timescale 1ns / 1ps
`default_nettype none

module nmea_rmc_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel_i,
  input  wire logic                              penable_i,
  input  wire logic                              pwrite_i,
  input  wire logic [nmea_rmc_pkg::PADDR_W-1:0] paddr_i,
  input  wire logic [nmea_rmc_pkg::PDATA_W-1:0] pwdata_i,
  output logic      [nmea_rmc_pkg::PDATA_W-1:0] prdata_o,
  output logic                                   pready_o,
  output logic      [nmea_rmc_pkg::FIDX_W-1:0]  field_index_o
);
  import nmea_rmc_pkg::*;

  logic [FIDX_W-1:0] field_index_q;
  logic [FIDX_W-1:0] field_index_d;
  logic              wr_en;

  assign pready_o = 1'b1;

  // write decode on the access phase
  assign wr_en = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_FIELD_INDEX);

  always_comb begin
    field_index_d = field_index_q;
    if (wr_en) begin
      field_index_d = pwdata_i[FIDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_index_q <= FIELD_INDEX_RESET;
    end else begin
      field_index_q <= field_index_d;
    end
  end

  // read back
  always_comb begin
    prdata_o = '0;
    if (paddr_i[2] == REG_FIELD_INDEX) begin
      prdata_o = {{(PDATA_W-FIDX_W){1'b0}}, field_index_q};
    end
  end

  assign field_index_o = field_index_q;

endmodule

`default_nettype wire

// ===== sv/nmea_rmc_parser.sv =====
// sentence tracker and field value accumulator, one byte per cycle while take_i is high
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_rmc_speed_extractor_macros.svh"

module nmea_rmc_parser (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [nmea_rmc_pkg::BYTE_W-1:0] byte_i,
  input  wire logic                             take_i,
  input  wire logic [nmea_rmc_pkg::FIDX_W-1:0] field_index_i,
  output nmea_rmc_pkg::rmc_result_t             res_o
);
  import nmea_rmc_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_COUNT = 2'd1;
  localparam logic [1:0] PH_FIELD = 2'd2;

  localparam int WIDE_W = SPEED_W + 3;

  logic [BYTE_W-1:0]  prev_q, prev_d;
  logic [1:0]         phase_q, phase_d;
  logic [FIDX_W-1:0]  cnt_q, cnt_d;
  logic [SPEED_W-1:0] acc_q, acc_d;
  logic [1:0]         frac_q, frac_d;
  logic               point_q, point_d;
  logic               stop_q, stop_d;
  logic               ovf_q, ovf_d;

  logic               is_digit;
  logic [3:0]         digit;
  logic [WIDE_W-1:0]  int_val;
  logic [6:0]         frac_add;
  logic [FIDX_W-1:0]  cnt_inc;
  logic               emit;

  assign is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign digit    = byte_i[3:0];
  assign cnt_inc  = cnt_q + 1'b1;

  // integer digit shifts the value up a decade, in hundredths
  assign int_val  = {3'b000, acc_q} * WIDE_W'(10)
                  + {{(WIDE_W-4){1'b0}}, digit} * WIDE_W'(100);
  assign frac_add = (frac_q == 2'd0) ? 7'(digit) * 7'd10 : 7'(digit);

  // next state
  always_comb begin
    prev_d  = byte_i;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    point_d = point_q;
    stop_d  = stop_q;
    ovf_d   = ovf_q;
    emit    = 1'b0;

    if (byte_i == CHAR_DOLLAR) begin
      phase_d = PH_IDLE;
    end else begin
      case (phase_q)
        PH_COUNT: begin
          if (byte_i == CHAR_COMMA) begin
            cnt_d = cnt_inc;
            if (cnt_inc == field_index_i) begin
              phase_d = PH_FIELD;
              acc_d   = '0;
              frac_d  = '0;
              point_d = 1'b0;
              stop_d  = 1'b0;
              ovf_d   = 1'b0;
            end
          end
        end
        PH_FIELD: begin
          if (byte_i == CHAR_COMMA) begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end else if (!stop_q) begin
            if (is_digit) begin
              if (!point_q) begin
                if (ovf_q || (int_val > {3'b000, SPEED_MAX})) begin
                  ovf_d = 1'b1;
                  acc_d = SPEED_MAX;
                end else begin
                  acc_d = int_val[SPEED_W-1:0];
                end
              end else if (frac_q != 2'd2) begin
                if (!ovf_q) begin
                  acc_d = acc_q + {{(SPEED_W-7){1'b0}}, frac_add};
                end
                frac_d = frac_q + 1'b1;
              end
            end else if ((byte_i == CHAR_POINT) && !point_q) begin
              point_d = 1'b1;
            end else begin
              stop_d = 1'b1;
            end
          end
        end
        default: begin
          // idle, and the unused code behaves as idle
          phase_d = PH_IDLE;
          if ((byte_i == CHAR_R) && (prev_q == CHAR_P)) begin
            cnt_d = '0;
            if (field_index_i == '0) begin
              phase_d = PH_FIELD;
              acc_d   = '0;
              frac_d  = '0;
              point_d = 1'b0;
              stop_d  = 1'b0;
              ovf_d   = 1'b0;
            end else begin
              phase_d = PH_COUNT;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      frac_q  <= '0;
      point_q <= 1'b0;
      stop_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (take_i) begin
      prev_q  <= prev_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      point_q <= point_d;
      stop_q  <= stop_d;
      ovf_q   <= ovf_d;
    end
  end

  assign res_o.emit  = emit;
  assign res_o.speed = acc_q;
  assign res_o.sat   = ovf_q;

  // accumulator stays within the clamp
  `NMEA_RMC_ASSERT(a_acc_range, acc_q <= SPEED_MAX, "accumulator above clamp")
  // an overflowed field holds exactly the clamp value
  `NMEA_RMC_ASSERT(a_ovf_clamp, ovf_q |-> (acc_q == SPEED_MAX), "overflow without clamp")
  // fraction digits only count after the point
  `NMEA_RMC_ASSERT(a_frac_point, (frac_q != 2'd0) |-> point_q, "fraction before point")

endmodule

`default_nettype wire
